// File: hw/rtl/pms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic mobility stencil package
// Shared constants, register codes and pipeline tag type.
// ----------------------------------------------------------------------------
package pms_pkg;

  localparam int ADDR_W      = 15;
  localparam int DATA_W      = 32;
  localparam int STORE_DEPTH = 32768;
  localparam int RECIP_SH    = 24;
  localparam int NUM_AX      = 3;
  localparam int ACC_W       = 102;

  typedef enum logic [2:0] {
    CFG_COEF_X       = 3'd0,
    CFG_COEF_Y       = 3'd1,
    CFG_COEF_Z       = 3'd2,
    CFG_CENTRAL_MODE = 3'd3,
    CFG_FIXED_EDGES  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_e;

  typedef struct packed {
    logic              compute;
    logic              zero;
    logic              err;
    logic [ADDR_W-1:0] pos;
  } tag_t;

endpackage
`default_nettype wire

// File: hw/rtl/pms_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sample store
// One write port, two registered read ports held while the pipeline stalls.
// ----------------------------------------------------------------------------
module pms_ram import pms_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_a_i,
  input  wire logic [ADDR_W-1:0] raddr_b_i,
  output logic      [DATA_W-1:0] rdata_a_o,
  output logic      [DATA_W-1:0] rdata_b_o
);

  logic [DATA_W-1:0] mem_q [STORE_DEPTH];
  logic [DATA_W-1:0] rdata_a_q, rdata_b_q;

  // write and read the array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (en_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

// File: hw/rtl/periodic_mobility_stencil_3d.sv
// Throughput: one item per cycle; the 12-stage pipeline advances as a whole
// and stops only when the output register holds an item not yet taken.
// The stores are replicated dual-read RAMs so all 14 samples are read in the same cycle.
// Reset clears valid bits and configuration registers; the stores and data registers are not cleared.
`default_nettype none
// ----------------------------------------------------------------------------
// Periodic mobility stencil, 3D
// Variable-coefficient 7-point Laplacian on a periodic grid, Q16.16.
// ----------------------------------------------------------------------------
module periodic_mobility_stencil_3d import pms_pkg::*; #(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [2:0]               cfg_index_i,
  input  wire logic [DATA_W-1:0]        cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     op_i,
  input  wire logic [ADDR_W-1:0]        position_i,
  input  wire logic signed [DATA_W-1:0] field_value_i,
  input  wire logic signed [DATA_W-1:0] density_value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [DATA_W-1:0]      result_value_o,
  output logic [ADDR_W-1:0]             result_position_o,
  output logic                          saturated_o,
  output logic                          edge_error_o
);

  localparam int XW     = $clog2(GRID_X);
  localparam int YW     = $clog2(GRID_Y);
  localparam int ZW     = $clog2(GRID_Z);
  localparam int NTOT   = GRID_X * GRID_Y * GRID_Z;
  localparam int GYZ    = GRID_Y * GRID_Z;
  localparam logic [22:0] RECIP_Z = 23'(((1 << RECIP_SH) + GRID_Z - 1) / GRID_Z);
  localparam logic [22:0] RECIP_Y = 23'(((1 << RECIP_SH) + GRID_Y - 1) / GRID_Y);

  // --------------------------------------------------------------------------
  // helpers
  function automatic logic [8:0] wrap_up(logic [8:0] i, logic [8:0] s, logic [8:0] n);
    logic [8:0] t;
    t = i + s;
    return (t >= n) ? 9'(t - n) : t;
  endfunction

  function automatic logic [8:0] wrap_dn(logic [8:0] i, logic [8:0] s, logic [8:0] n);
    return (i >= s) ? 9'(i - s) : 9'(i + n - s);
  endfunction

  function automatic logic [ADDR_W-1:0] lin(logic [8:0] ix, logic [8:0] iy, logic [8:0] iz);
    logic [31:0] t;
    t = 32'(ix) * 32'(GYZ) + 32'(iy) * 32'(GRID_Z) + 32'(iz);
    return t[ADDR_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // configuration registers
  logic [DATA_W-1:0] coef_q [NUM_AX];
  logic              central_q, fixed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= 32'd65536;
      coef_q[1] <= 32'd65536;
      coef_q[2] <= 32'd65536;
      central_q <= 1'b0;
      fixed_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_COEF_X:       coef_q[0] <= cfg_data_i;
        CFG_COEF_Y:       coef_q[1] <= cfg_data_i;
        CFG_COEF_Z:       coef_q[2] <= cfg_data_i;
        CFG_CENTRAL_MODE: central_q <= cfg_data_i[0];
        CFG_FIXED_EDGES:  fixed_q   <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline enable: advance unless the output item waits
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // valid bits, one per stage
  logic [12:1] v_q, v_d;

  // stage 1..5 payload
  logic              op1_q, op2_q, op3_q, op4_q, op5_q;
  logic [ADDR_W-1:0] pos1_q, pos2_q, pos3_q, pos4_q, pos5_q;
  logic [DATA_W-1:0] fv1_q, fv2_q, fv3_q, fv4_q, fv5_q;
  logic [DATA_W-1:0] dv1_q, dv2_q, dv3_q, dv4_q, dv5_q;
  logic [ADDR_W-1:0] q1_2_q, q1_3_q, q2_3_q;
  logic [ZW-1:0]     iz3_q, iz4_q;
  logic [XW-1:0]     ix4_q;
  logic [YW-1:0]     iy4_q;
  logic              inr4_q, inr5_q, edge4_q, edge5_q;
  logic [ADDR_W-1:0] fa_q [8];
  logic [ADDR_W-1:0] da_q [8];

  // division steps by reciprocal multiplication
  logic [37:0]       prod_z, prod_y;
  logic [ADDR_W-1:0] q1_d, q2_d, iz_full, iy_full;
  assign prod_z  = 38'(pos1_q) * 38'(RECIP_Z);
  assign q1_d    = ADDR_W'(prod_z >> RECIP_SH);
  assign prod_y  = 38'(q1_2_q) * 38'(RECIP_Y);
  assign q2_d    = ADDR_W'(prod_y >> RECIP_SH);
  assign iz_full = ADDR_W'(pos2_q - ADDR_W'(32'(q1_2_q) * 32'(GRID_Z)));
  assign iy_full = ADDR_W'(q1_3_q - ADDR_W'(32'(q2_3_q) * 32'(GRID_Y)));

  // neighbour addresses
  logic [8:0]        sx, ix9, iy9, iz9;
  logic [ADDR_W-1:0] fa_d [8];
  logic [ADDR_W-1:0] da_d [8];
  always_comb begin
    sx  = central_q ? 9'd2 : 9'd1;
    ix9 = 9'(ix4_q);
    iy9 = 9'(iy4_q);
    iz9 = 9'(iz4_q);
    fa_d[0] = pos4_q;
    fa_d[1] = lin(wrap_up(ix9, sx, 9'(GRID_X)), iy9, iz9);
    fa_d[2] = lin(wrap_dn(ix9, sx, 9'(GRID_X)), iy9, iz9);
    fa_d[3] = lin(ix9, wrap_up(iy9, sx, 9'(GRID_Y)), iz9);
    fa_d[4] = lin(ix9, wrap_dn(iy9, sx, 9'(GRID_Y)), iz9);
    fa_d[5] = lin(ix9, iy9, wrap_up(iz9, sx, 9'(GRID_Z)));
    fa_d[6] = lin(ix9, iy9, wrap_dn(iz9, sx, 9'(GRID_Z)));
    fa_d[7] = fa_d[6];
    da_d[0] = pos4_q;
    da_d[1] = lin(wrap_up(ix9, 9'd1, 9'(GRID_X)), iy9, iz9);
    da_d[2] = lin(wrap_dn(ix9, 9'd1, 9'(GRID_X)), iy9, iz9);
    da_d[3] = lin(ix9, wrap_up(iy9, 9'd1, 9'(GRID_Y)), iz9);
    da_d[4] = lin(ix9, wrap_dn(iy9, 9'd1, 9'(GRID_Y)), iz9);
    da_d[5] = lin(ix9, iy9, wrap_up(iz9, 9'd1, 9'(GRID_Z)));
    da_d[6] = lin(ix9, iy9, wrap_dn(iz9, 9'd1, 9'(GRID_Z)));
    da_d[7] = da_d[6];
  end

  // edge test on decoded indices
  logic inr_d, edge_d;
  assign inr_d  = 32'(pos3_q) < NTOT;
  assign edge_d = fixed_q && (q2_3_q == '0 || iy_full == '0 || iz3_q == '0);

  // front stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      op1_q  <= op_i;
      pos1_q <= position_i;
      fv1_q  <= field_value_i;
      dv1_q  <= density_value_i;
      op2_q  <= op1_q;  pos2_q <= pos1_q; fv2_q <= fv1_q; dv2_q <= dv1_q;
      q1_2_q <= q1_d;
      op3_q  <= op2_q;  pos3_q <= pos2_q; fv3_q <= fv2_q; dv3_q <= dv2_q;
      q1_3_q <= q1_2_q;
      q2_3_q <= q2_d;
      iz3_q  <= ZW'(iz_full);
      op4_q  <= op3_q;  pos4_q <= pos3_q; fv4_q <= fv3_q; dv4_q <= dv3_q;
      ix4_q  <= XW'(q2_3_q);
      iy4_q  <= YW'(iy_full);
      iz4_q  <= iz3_q;
      inr4_q <= inr_d;
      edge4_q <= edge_d;
      op5_q  <= op4_q;  pos5_q <= pos4_q; fv5_q <= fv4_q; dv5_q <= dv4_q;
      inr5_q <= inr4_q;
      edge5_q <= edge4_q;
      fa_q   <= fa_d;
      da_q   <= da_d;
    end
  end

  // --------------------------------------------------------------------------
  // replicated stores: every copy takes every load
  logic              mem_we;
  logic [DATA_W-1:0] fr [8];
  logic [DATA_W-1:0] dr [8];
  assign mem_we = en && v_q[5] && (op5_q == OP_LOAD) && inr5_q;

  for (genvar g = 0; g < 4; g++) begin : g_store
    pms_ram u_field (
      .clk_i     (clk_i),
      .en_i      (en),
      .we_i      (mem_we),
      .waddr_i   (pos5_q),
      .wdata_i   (fv5_q),
      .raddr_a_i (fa_q[2*g]),
      .raddr_b_i (fa_q[2*g+1]),
      .rdata_a_o (fr[2*g]),
      .rdata_b_o (fr[2*g+1])
    );
    pms_ram u_density (
      .clk_i     (clk_i),
      .en_i      (en),
      .we_i      (mem_we),
      .waddr_i   (pos5_q),
      .wdata_i   (dv5_q),
      .raddr_a_i (da_q[2*g]),
      .raddr_b_i (da_q[2*g+1]),
      .rdata_a_o (dr[2*g]),
      .rdata_b_o (dr[2*g+1])
    );
  end

  // --------------------------------------------------------------------------
  // arithmetic stages
  tag_t tag6_q, tag7_q, tag8_q, tag9_q, tag10_q, tag11_q, tag12_q;
  tag_t tag6_d, tag7_d;
  logic edge_flag6_q;

  always_comb begin
    tag6_d.compute = (op5_q == OP_COMPUTE);
    tag6_d.zero    = !inr5_q || edge5_q;
    tag6_d.err     = 1'b0;
    tag6_d.pos     = pos5_q;
    tag7_d         = tag6_q;
    tag7_d.err     = edge_flag6_q && (fr[0] != '0);
  end

  // differences and sums of neighbours
  logic signed [32:0] aup_d [NUM_AX], bup_d [NUM_AX], adn_d [NUM_AX], bdn_d [NUM_AX];
  logic signed [32:0] aup_q [NUM_AX], bup_q [NUM_AX], adn_q [NUM_AX], bdn_q [NUM_AX];
  logic        [31:0] d0;
  always_comb begin
    d0 = central_q ? '0 : dr[0];
    for (int a = 0; a < NUM_AX; a++) begin
      aup_d[a] = {dr[1+2*a][31], dr[1+2*a]} + {d0[31], d0};
      bup_d[a] = {fr[1+2*a][31], fr[1+2*a]} - {fr[0][31], fr[0]};
      adn_d[a] = {d0[31], d0} + {dr[2+2*a][31], dr[2+2*a]};
      bdn_d[a] = {fr[0][31], fr[0]} - {fr[2+2*a][31], fr[2+2*a]};
    end
  end

  // products, term, coefficient products, axis totals
  logic signed [65:0]  up_q [NUM_AX], dn_q [NUM_AX];
  logic        [66:0]  term_q [NUM_AX];
  logic        [65:0]  plo_q [NUM_AX];
  logic signed [65:0]  phi_q [NUM_AX];
  logic        [99:0]  axis_q [NUM_AX];
  logic        [ACC_W-1:0] tot_q;
  logic signed [65:0]  up_d [NUM_AX], dn_d [NUM_AX], phi_d [NUM_AX];
  logic        [66:0]  term_d [NUM_AX];
  logic        [65:0]  plo_d [NUM_AX];
  logic        [99:0]  axis_d [NUM_AX];
  logic        [ACC_W-1:0] tot_d, half;

  always_comb begin
    for (int a = 0; a < NUM_AX; a++) begin
      up_d[a]   = aup_q[a] * bup_q[a];
      dn_d[a]   = adn_q[a] * bdn_q[a];
      term_d[a] = {up_q[a][65], up_q[a]} - {dn_q[a][65], dn_q[a]};
      plo_d[a]  = 66'(term_q[a][33:0]) * 66'(coef_q[a]);
      phi_d[a]  = $signed(term_q[a][66:34]) * $signed({1'b0, coef_q[a]});
      axis_d[a] = {phi_q[a], 34'd0} + {34'd0, plo_q[a]};
    end
    half  = central_q ? (ACC_W'(1) << 33) : (ACC_W'(1) << 32);
    tot_d = {{2{axis_q[0][99]}}, axis_q[0]} + {{2{axis_q[1][99]}}, axis_q[1]}
          + {{2{axis_q[2][99]}}, axis_q[2]} + half;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tag6_q       <= tag6_d;
      edge_flag6_q <= edge5_q && inr5_q;
      tag7_q       <= tag7_d;
      aup_q <= aup_d; bup_q <= bup_d; adn_q <= adn_d; bdn_q <= bdn_d;
      tag8_q  <= tag7_q;
      up_q    <= up_d;
      dn_q    <= dn_d;
      tag9_q  <= tag8_q;
      term_q  <= term_d;
      tag10_q <= tag9_q;
      plo_q   <= plo_d;
      phi_q   <= phi_d;
      tag11_q <= tag10_q;
      axis_q  <= axis_d;
      tag12_q <= tag11_q;
      tot_q   <= tot_d;
    end
  end

  // --------------------------------------------------------------------------
  // round, clip and hold the result
  logic signed [ACC_W-1:0] sh;
  logic                    fits;
  logic [DATA_W-1:0]       val_d;
  logic                    sat_d;
  always_comb begin
    sh    = central_q ? ($signed(tot_q) >>> 34) : ($signed(tot_q) >>> 33);
    fits  = (&sh[ACC_W-1:31]) || !(|sh[ACC_W-1:31]);
    val_d = fits ? sh[31:0] : (sh[ACC_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
    sat_d = !fits;
    if (tag12_q.zero) begin
      val_d = '0;
      sat_d = 1'b0;
    end
  end

  logic [DATA_W-1:0] val_q;
  logic [ADDR_W-1:0] rpos_q;
  logic              sat_q, err_q;

  always_comb begin
    v_d     = v_q;
    v_d[1]  = in_valid_i;
    v_d[12:2] = v_q[11:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v_q         <= v_d;
      out_valid_q <= v_q[12] && tag12_q.compute;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      val_q  <= val_d;
      sat_q  <= sat_d;
      err_q  <= tag12_q.err;
      rpos_q <= tag12_q.pos;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_value_o    = val_q;
  assign result_position_o = rpos_q;
  assign saturated_o       = sat_q;
  assign edge_error_o      = err_q;

`ifndef SYNTHESIS
  // an edge error only comes with a forced zero result
  a_edge_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edge_error_o |-> result_value_o == '0 && !saturated_o)
    else $error("edge error with nonzero result");

  // a clipped result sits at one of the range limits
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      result_value_o == 32'h7FFF_FFFF || result_value_o == 32'h8000_0000)
    else $error("saturated result not at a limit");

  // a stall freezes the pipeline
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q) && $stable(tag12_q.pos) && $stable(fa_q[0]))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
